/* rtl/gpd_pkg.sv */
// ----------------------------------------------------------------------------
// gpd_pkg: growth plateau detector shared definitions
// Group size, derived field widths, payload types and the reciprocal
// constant used to form the block mean without a divider.
// ----------------------------------------------------------------------------
package gpd_pkg;

  // Samples per block, means per group and variations per check (2..16)
  localparam int GROUP_SIZE = 8;

  localparam int SAMPLE_W = 16;
  localparam int LOG_G    = $clog2(GROUP_SIZE);
  localparam int CNT_W    = (LOG_G < 1) ? 1 : LOG_G;
  // Block sum holds GROUP_SIZE samples
  localparam int SUM_W    = SAMPLE_W + LOG_G;
  // Mean in eighths never exceeds the largest sample times eight
  localparam int MEAN_W   = SAMPLE_W + 3;
  // Variation: signed difference of two means
  localparam int VAR_W    = MEAN_W + 1;
  // Variation sum, also holds one variation scaled by GROUP_SIZE
  localparam int VSUM_W   = VAR_W + LOG_G + 1;

  // floor(x / GROUP_SIZE) = (x * RECIP) >> RECIP_SH, exact for x < 2**X_W
  localparam int X_W      = SUM_W + 3;
  localparam int RECIP_SH = X_W + LOG_G;
  localparam int RECIP_W  = X_W + 1;
  localparam int PROD_W   = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE));

  // Last count value of a block or group
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic [MEAN_W-1:0]        mean_t;
  typedef logic signed [VAR_W-1:0]  variation_t;

endpackage

/* rtl/gpd_in_if.sv */
// ----------------------------------------------------------------------------
// gpd_in_if: sample channel
// Valid/ready channel carrying one size sample per beat.
// ----------------------------------------------------------------------------
interface gpd_in_if
  import gpd_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t size_sample;

  modport source (output valid, output size_sample, input ready);
  modport sink   (input valid, input size_sample, output ready);
endinterface

/* rtl/gpd_out_if.sv */
// ----------------------------------------------------------------------------
// gpd_out_if: result channel
// Valid/ready channel carrying the growth flag, check strobe and the
// most recent variation per beat.
// ----------------------------------------------------------------------------
interface gpd_out_if
  import gpd_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic       still_growing;
  logic       check_done;
  variation_t latest_variation;

  modport source (output valid, output still_growing, output check_done,
                  output latest_variation, input ready);
  modport sink   (input valid, input still_growing, input check_done,
                  input latest_variation, output ready);
endinterface

/* rtl/growth_plateau_detector_top.sv */
// ----------------------------------------------------------------------------
// growth_plateau_detector_top: growth plateau detector
// Block means, per-group variations and a one-way growing flag.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one size sample per beat (valid/ready).
//   results : one beat per sample: growing flag after that sample, a strobe
//             when the sample closed a group of variations, and the most
//             recent variation in eighths.
//   The first GROUP_SIZE samples after reset are a warm-up and are dropped
//   from the statistics, though each still yields a result beat.
// Pipeline: the beat edge loads the accumulate stage, then the mean
//   multiply stage and the variation/compare result register load in turn.
// Throughput: one sample per cycle when not stalled; the per-stage
//   handshake lets every stage hold one beat, the multiply stage sets
//   the longest path.
// Reset: synchronous, clears all counters and sums, sets the growing flag
//   and empties the pipeline.
// Stall: while the result register is held, upstream stages keep filling
//   until all three hold a beat; then samples.ready drops.
// ----------------------------------------------------------------------------
module growth_plateau_detector_top
  import gpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gpd_in_if.sink      samples,
  gpd_out_if.source   results
);

  // Pipeline handshake
  logic s1_valid, s2_valid, o_valid;
  logic out_load, s2_load, s1_load, accept, s3_fire;

  assign out_load      = !o_valid || results.ready;
  assign s2_load       = !s2_valid || out_load;
  assign s1_load       = !s1_valid || s2_load;
  assign samples.ready = s1_load;
  assign accept        = samples.valid && s1_load;
  assign s3_fire       = s2_valid && out_load;

  // ---------------- Stage 1: warm-up and block accumulation ----------------
  logic [CNT_W-1:0] sample_count, sample_count_next;
  logic             warmup_done, warmup_done_next;
  logic [SUM_W-1:0] block_sum, block_sum_next, sum_acc;
  logic             blk_end;
  logic             s1_blk;
  logic [SUM_W-1:0] s1_sum;

  assign sum_acc = block_sum + SUM_W'(samples.size_sample);
  assign blk_end = (sample_count == CNT_LAST);

  always_comb begin
    sample_count_next = blk_end ? '0 : sample_count + CNT_W'(1);
    warmup_done_next  = warmup_done || blk_end;
    block_sum_next    = block_sum;
    if (warmup_done) begin
      block_sum_next = blk_end ? '0 : sum_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      warmup_done  <= 1'b0;
      block_sum    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        sample_count <= sample_count_next;
        warmup_done  <= warmup_done_next;
        block_sum    <= block_sum_next;
      end
      if (s1_load) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blk <= warmup_done && blk_end;
      s1_sum <= sum_acc;
    end
  end

  // ---------------- Stage 2: mean = floor(sum * 8 / GROUP_SIZE) ------------
  logic [PROD_W-1:0] prod;
  logic              s2_blk;
  mean_t             s2_mean;

  assign prod = PROD_W'({s1_sum, 3'b000}) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_blk  <= s1_valid && s1_blk;
      s2_mean <= MEAN_W'(prod >> RECIP_SH);
    end
  end

  // ---------------- Stage 3: variation, group check, growing flag ----------
  logic [CNT_W-1:0]         mean_count, mean_count_next;
  mean_t                    first_mean, first_mean_next;
  logic [CNT_W-1:0]         var_count, var_count_next;
  logic signed [VSUM_W-1:0] var_sum, var_sum_next, vsum_acc;
  variation_t               last_variation, last_variation_next;
  logic                     growing, growing_next;
  logic                     checked;
  variation_t               v;
  logic signed [VSUM_W-1:0] v_ext, v_scaled;

  assign v        = $signed({1'b0, s2_mean}) - $signed({1'b0, first_mean});
  assign v_ext    = {{(VSUM_W - VAR_W){v[VAR_W-1]}}, v};
  assign vsum_acc = var_sum + v_ext;
  assign v_scaled = v_ext * $signed(VSUM_W'(GROUP_SIZE));

  always_comb begin
    mean_count_next     = mean_count;
    first_mean_next     = first_mean;
    var_count_next      = var_count;
    var_sum_next        = var_sum;
    last_variation_next = last_variation;
    growing_next        = growing;
    checked             = 1'b0;
    if (s2_blk) begin
      if (mean_count == '0) begin
        first_mean_next = s2_mean;
      end
      if (mean_count == CNT_LAST) begin
        mean_count_next     = '0;
        last_variation_next = v;
        var_sum_next        = vsum_acc;
        if (var_count == CNT_LAST) begin
          var_count_next = '0;
          var_sum_next   = '0;
          checked        = 1'b1;
          if (v_scaled < vsum_acc) begin
            growing_next = 1'b0;
          end
        end else begin
          var_count_next = var_count + CNT_W'(1);
        end
      end else begin
        mean_count_next = mean_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_count     <= '0;
      var_count      <= '0;
      var_sum        <= '0;
      last_variation <= '0;
      growing        <= 1'b1;
      o_valid        <= 1'b0;
    end else begin
      if (s3_fire) begin
        mean_count     <= mean_count_next;
        var_count      <= var_count_next;
        var_sum        <= var_sum_next;
        last_variation <= last_variation_next;
        growing        <= growing_next;
      end
      if (out_load) begin
        o_valid <= s2_valid;
      end
    end
  end

  // First mean of a group: written before it is ever read
  always_ff @(posedge clk) begin
    if (s3_fire) begin
      first_mean <= first_mean_next;
    end
  end

  // Result register
  logic       o_grow, o_chk;
  variation_t o_var;

  always_ff @(posedge clk) begin
    if (s3_fire) begin
      o_grow <= growing_next;
      o_chk  <= checked;
      o_var  <= last_variation_next;
    end
  end

  assign results.valid            = o_valid;
  assign results.still_growing    = o_grow;
  assign results.check_done       = o_chk;
  assign results.latest_variation = o_var;

  // ---------------- Assertions ----------------
  // Growing flag is one-way until reset
  a_no_regrow: assert property (@(posedge clk) disable iff (rst) !$rose(growing))
    else $error("growing flag set again after a plateau");

  // An empty result register never blocks the sample side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> samples.ready)
    else $error("sample side stalled with empty result register");

  // A held check beat leaves the group counters at their start
  a_check_counters: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.check_done) |-> (var_count == '0 && mean_count == '0))
    else $error("group counters not restarted after a check");

endmodule

/* tb/tb_growth_plateau_detector_top.sv */
// ----------------------------------------------------------------------------
// tb_growth_plateau_detector_top: growth plateau detector testbench
// Streams size samples through the detector with bursty input and a stalling
// result side. A scoreboard keeps its own block, mean and variation
// accumulators and checks every result beat field by field, in order.
// Sample shaping lets the variation checks see a steep rise (flag kept) and
// a steep fall (flag cleared), after which the result beats carry the low flag.
// ----------------------------------------------------------------------------
module tb_growth_plateau_detector_top;
  import gpd_pkg::*;

  // Warm-up, two full groups of variations and a tail, so two checks are made
  localparam int N_SAMPLES  = 1100;
  localparam int N_DIRECTED = 24;
  localparam int DRAIN_WAIT = 8;

  typedef struct {
    logic       still_growing;
    logic       check_done;
    variation_t latest_variation;
  } plateau_result_t;

  // Tracks detector state per accepted beat and holds the expected results
  class plateau_scoreboard;
    plateau_result_t          expected_q[$];
    int                       fails;
    logic [CNT_W-1:0]         smp_cnt;
    logic                     warm;
    logic [SUM_W-1:0]         blk_sum;
    logic [CNT_W-1:0]         mean_cnt;
    mean_t                    first_mean;
    logic [CNT_W-1:0]         var_cnt;
    logic signed [VSUM_W-1:0] var_sum;
    variation_t               last_var;
    logic                     growing;

    function new();
      fails      = 0;
      smp_cnt    = '0;
      warm       = 1'b0;
      blk_sum    = '0;
      mean_cnt   = '0;
      first_mean = '0;
      var_cnt    = '0;
      var_sum    = '0;
      last_var   = '0;
      growing    = 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the detector state by one sample and queue the result beat
    function void note_sample(sample_t s);
      plateau_result_t r;
      mean_t           mean;
      variation_t      var_now;
      logic            checked;
      checked = 1'b0;
      if (!warm) begin
        // warm-up block: counted, not summed
        if (smp_cnt == CNT_LAST) begin
          smp_cnt = '0;
          warm    = 1'b1;
        end else begin
          smp_cnt++;
        end
      end else begin
        blk_sum = blk_sum + SUM_W'(s);
        if (smp_cnt == CNT_LAST) begin
          smp_cnt = '0;
          // mean in eighths, truncated
          mean    = mean_t'({blk_sum, 3'b000} / GROUP_SIZE);
          blk_sum = '0;
          if (mean_cnt == '0) first_mean = mean;
          if (mean_cnt == CNT_LAST) begin
            mean_cnt = '0;
            var_now  = $signed({1'b0, mean}) - $signed({1'b0, first_mean});
            last_var = var_now;
            var_sum  = var_sum + var_now;
            if (var_cnt == CNT_LAST) begin
              var_cnt = '0;
              // last variation strictly below the group mean clears the flag
              if (longint'(var_now) * GROUP_SIZE < longint'(var_sum)) growing = 1'b0;
              var_sum = '0;
              checked = 1'b1;
            end else begin
              var_cnt++;
            end
          end else begin
            mean_cnt++;
          end
        end else begin
          smp_cnt++;
        end
      end
      r.still_growing    = growing;
      r.check_done       = checked;
      r.latest_variation = last_var;
      expected_q.push_back(r);
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(logic sg, logic cd, variation_t lv);
      plateau_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected (growing %0b, done %0b, var %0d)",
                 $time, sg, cd, lv);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (sg !== e.still_growing) begin
        $display("%0t: still_growing expected %0b actual %0b", $time, e.still_growing, sg);
        fails++;
      end
      if (cd !== e.check_done) begin
        $display("%0t: check_done expected %0b actual %0b", $time, e.check_done, cd);
        fails++;
      end
      if (lv !== e.latest_variation) begin
        $display("%0t: latest_variation expected %0d actual %0d",
                 $time, e.latest_variation, lv);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  gpd_in_if  samples();
  gpd_out_if results();

  growth_plateau_detector_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  plateau_scoreboard sb;

  // Extremes and bit patterns in the warm-up, then an all-zero and an all-max block
  sample_t directed_vals [0:N_DIRECTED-1] = '{
    16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
  };

  // Current group-of-means shape: a ramp lvl_lo to lvl_hi plus noise, or pure noise
  int lvl_lo;
  int lvl_hi;
  int noise_amp;
  bit full_noise;

  // Result-side stall pattern
  logic [15:0] ready_mask  = 16'hFFFF;
  int          ready_pos   = 0;
  int          window_left = 32;
  int          pick;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_growth_plateau_detector_top: errors");
    $finish;
  end

  // Sample value for a given stream position
  function automatic sample_t sample_for(int idx);
    int blk;
    int lvl;
    if (idx < N_DIRECTED) return directed_vals[idx];
    if (full_noise) return sample_t'($urandom_range(0, 65535));
    blk = ((idx - GROUP_SIZE) / GROUP_SIZE) % GROUP_SIZE;
    lvl = lvl_lo + (lvl_hi - lvl_lo) * blk / (GROUP_SIZE - 1);
    lvl = lvl + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
    if (lvl < 0) lvl = 0;
    if (lvl > 65535) lvl = 65535;
    return sample_t'(lvl);
  endfunction

  // One beat on the sample channel; returns at the accepting edge
  task automatic put_sample(input sample_t s);
    samples.valid       <= 1'b1;
    samples.size_sample <= s;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      samples.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off input until every expected result has come back
  task automatic drain_results();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Beat monitor, checker and result-side stall driver
  always @(posedge clk) begin
    if (!rst && samples.valid && samples.ready) sb.note_sample(samples.size_sample);
    if (!rst && results.valid && results.ready) begin
      sb.check_result(results.still_growing, results.check_done, results.latest_variation);
    end
    if (window_left == 0) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) ready_mask = 16'hFFFF;
      else if (pick == 1) ready_mask = 16'($urandom) | 16'h0001;
      else if (pick == 2) ready_mask = 16'($urandom & $urandom) | 16'h0001;
      else ready_mask = ~16'($urandom & $urandom) | 16'h0001;
      window_left = $urandom_range(16, 96);
    end else begin
      window_left--;
    end
    results.ready <= ready_mask[ready_pos];
    ready_pos = (ready_pos + 1) % 16;
  end

  // Stimulus
  initial begin
    int idx;
    int mg;
    int burst_left;
    int gap;
    sb                  = new();
    lvl_lo              = 0;
    lvl_hi              = 65535;
    noise_amp           = 0;
    full_noise          = 1'b0;
    burst_left          = 0;
    rst                 <= 1'b1;
    samples.valid       <= 1'b0;
    samples.size_sample <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < N_SAMPLES; idx++) begin
      // new group of means: pick its shape
      if (idx > GROUP_SIZE && (idx - GROUP_SIZE) % (GROUP_SIZE * GROUP_SIZE) == 0) begin
        mg = (idx - GROUP_SIZE) / (GROUP_SIZE * GROUP_SIZE);
        if (mg % GROUP_SIZE == GROUP_SIZE - 1 && mg / GROUP_SIZE < 2) begin
          // first check sees a full-scale rise, the second a full-scale fall
          lvl_lo     = (mg / GROUP_SIZE == 0) ? 0 : 65535;
          lvl_hi     = 65535 - lvl_lo;
          noise_amp  = 0;
          full_noise = 1'b0;
        end else begin
          full_noise = ($urandom_range(0, 7) == 0);
          lvl_lo     = $urandom_range(0, 65535);
          lvl_hi     = $urandom_range(0, 65535);
          noise_amp  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2047);
        end
      end
      if (idx == 300 || idx == 1000) drain_results();
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 40);
        idle_cycles(gap);
      end
      put_sample(sample_for(idx));
      burst_left--;
    end
    samples.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb_growth_plateau_detector_top: clean");
    end else begin
      $display("tb_growth_plateau_detector_top: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gpd_pkg.sv
rtl/gpd_in_if.sv
rtl/gpd_out_if.sv
rtl/growth_plateau_detector_top.sv
tb/tb_growth_plateau_detector_top.sv
